// File: rtl/core/ucd_pkg.sv
// shared types, constants and checksum function of the usb can frame deframer
package ucd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned IdW      = 11;
	localparam int unsigned WordW    = 32;
	localparam int unsigned HeldLen  = 17;
	localparam int unsigned FillW    = 5;
	localparam int unsigned SumW     = 13;
	localparam int unsigned NumRegs  = 4;
	localparam int unsigned AddrW    = 4;
	localparam int unsigned DataW    = 32;
	localparam int unsigned QueueDepth = 2;

	localparam logic [ByteW-1:0] StartMark = 8'hF0;
	localparam logic [ByteW-1:0] TypeMark  = 8'h55;
	localparam logic [ByteW-1:0] ChanMark  = 8'hAA;

	localparam logic [IdW-1:0] MsgIdFirstRst  = 11'd1024;
	localparam logic [IdW-1:0] MsgIdLastRst   = 11'd1031;
	localparam logic [IdW-1:0] StatusIdRst    = 11'd1042;
	localparam logic [IdW-1:0] HeartbeatIdRst = 11'd1664;

	typedef enum logic [1:0] {
		REG_MSG_ID_FIRST,
		REG_MSG_ID_LAST,
		REG_STATUS_ID,
		REG_HEARTBEAT_ID
	} ucd_reg_t;

	typedef struct packed {
		logic [IdW-1:0]   can_id;
		logic [WordW-1:0] data_low;
		logic [WordW-1:0] data_high;
	} ucd_frame_t;

	typedef struct packed {
		logic [IdW-1:0] msg_id_first;
		logic [IdW-1:0] msg_id_last;
		logic [IdW-1:0] status_id;
		logic [IdW-1:0] heartbeat_id;
	} ucd_cfg_t;

	// sum folded twice with end-around carry, then negated
	function automatic logic [ByteW-1:0] frame_chk(input logic [SumW-1:0] sum);
		logic [ByteW:0] fold1;
		logic [ByteW:0] fold2;
		fold1 = {1'b0, sum[ByteW-1:0]} + {{(2*ByteW+1-SumW){1'b0}}, sum[SumW-1:ByteW]};
		fold2 = {1'b0, fold1[ByteW-1:0]} + {{ByteW{1'b0}}, fold1[ByteW]};
		return ByteW'((ByteW+1)'(0) - fold2);
	endfunction

endpackage

// File: rtl/core/ucd_channels.sv
// handshake channel interfaces for received bytes and decoded frames
interface ucd_rx_if;
	import ucd_pkg::*;
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ucd_res_if;
	import ucd_pkg::*;
	logic             valid;
	logic             ready;
	logic [IdW-1:0]   can_id;
	logic [WordW-1:0] data_low;
	logic [WordW-1:0] data_high;
	modport source (output valid, output can_id, output data_low, output data_high,
		input ready);
	modport sink (input valid, input can_id, input data_low, input data_high,
		output ready);
endinterface

// File: rtl/core/usb_can_frame_deframer.sv
// usb can frame deframer: received byte stream in, filtered can frames out
// The rx channel takes one received byte per transfer, one per cycle when the
// block is ready. Bytes fill a 17-byte sliding window; a frame starts with
// 0xF0 and ends with the folded negated checksum of its first 17 bytes. A
// matching frame consumes all 18 bytes, otherwise the oldest byte drops out.
// Frames of the right type and channel go through a small queue to the id
// filter; a frame that passes is offered on the res channel as one transfer.
// Throughput is one byte per cycle while the queue has room, set by the
// running window sum that is updated with each byte. A frame is written
// into the queue with its last byte, then loaded into the output register.
// When res stalls, the output register and the queue hold frames; rx ready
// drops only once the queue is full. Reset empties the window, queue and
// output register and loads the default filter ids. The id filter registers
// sit on the apb port at byte addresses 0, 4, 8, 12 and are to be written
// only while no frame is in flight; the block does not enforce this.
module usb_can_frame_deframer #(
	parameter int unsigned QueueDepth = ucd_pkg::QueueDepth
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ucd_rx_if.sink                    rx,
	ucd_res_if.source                 res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ucd_pkg::AddrW-1:0] paddr,
	input  logic [ucd_pkg::DataW-1:0] pwdata,
	output logic [ucd_pkg::DataW-1:0] prdata,
	output logic                      pready
);
	import ucd_pkg::*;

	ucd_cfg_t   cfg;
	logic       push_valid;
	logic       push_ready;
	ucd_frame_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	ucd_frame_t pop_data;

	ucd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ucd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	ucd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	ucd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.res       (res)
	);

endmodule

// File: rtl/core/ucd_cfg.sv
// apb register bank holding the id filter settings
module ucd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ucd_pkg::AddrW-1:0]    paddr,
	input  logic [ucd_pkg::DataW-1:0]    pwdata,
	output logic [ucd_pkg::DataW-1:0]    prdata,
	output logic                         pready,
	output ucd_pkg::ucd_cfg_t            cfg
);
	import ucd_pkg::*;

	ucd_cfg_t cfg_q;
	ucd_reg_t sel;
	logic     wr_en;

	assign sel    = ucd_reg_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msg_id_first <= MsgIdFirstRst;
			cfg_q.msg_id_last  <= MsgIdLastRst;
			cfg_q.status_id    <= StatusIdRst;
			cfg_q.heartbeat_id <= HeartbeatIdRst;
		end else if (wr_en) begin
			unique case (sel)
				REG_MSG_ID_FIRST: cfg_q.msg_id_first <= pwdata[IdW-1:0];
				REG_MSG_ID_LAST:  cfg_q.msg_id_last  <= pwdata[IdW-1:0];
				REG_STATUS_ID:    cfg_q.status_id    <= pwdata[IdW-1:0];
				REG_HEARTBEAT_ID: cfg_q.heartbeat_id <= pwdata[IdW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			REG_MSG_ID_FIRST: prdata = DataW'(cfg_q.msg_id_first);
			REG_MSG_ID_LAST:  prdata = DataW'(cfg_q.msg_id_last);
			REG_STATUS_ID:    prdata = DataW'(cfg_q.status_id);
			REG_HEARTBEAT_ID: prdata = DataW'(cfg_q.heartbeat_id);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/ucd_front.sv
// byte window, running checksum and frame detection
module ucd_front (
	input  logic                clk,
	input  logic                arst_n,
	ucd_rx_if.sink              rx,
	output logic                push_valid,
	output ucd_pkg::ucd_frame_t push_data,
	input  logic                push_ready
);
	import ucd_pkg::*;

	logic [ByteW-1:0] window_q [HeldLen];
	logic [FillW-1:0] fill_q;
	logic [SumW-1:0]  sum_q;
	logic             accept;
	logic             full;
	logic             is_frame;

	assign rx.ready = push_ready;
	assign accept   = rx.valid && rx.ready;
	assign full     = (fill_q == FillW'(HeldLen));
	assign is_frame = full && (window_q[0] == StartMark) &&
		(rx.rx_byte == frame_chk(sum_q));

	assign push_valid = accept && is_frame &&
		(window_q[1] == TypeMark) && (window_q[2] == ChanMark);
	assign push_data.can_id    = {window_q[4], window_q[5][ByteW-1 -: 3]};
	assign push_data.data_low  = {window_q[12], window_q[11], window_q[10], window_q[9]};
	assign push_data.data_high = {window_q[16], window_q[15], window_q[14], window_q[13]};

	// newest byte always enters at the top, oldest sits at index zero once full
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < HeldLen - 1; i++) begin
				window_q[i] <= window_q[i+1];
			end
			window_q[HeldLen-1] <= rx.rx_byte;
		end
	end

	// sum of held bytes kept incrementally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (!full) begin
				fill_q <= fill_q + FillW'(1);
				sum_q  <= sum_q + SumW'(rx.rx_byte);
			end else if (is_frame) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				sum_q <= sum_q - SumW'(window_q[0]) + SumW'(rx.rx_byte);
			end
		end
	end

endmodule

// File: rtl/core/ucd_queue.sv
// small fifo between frame detection and result output
module ucd_queue #(
	parameter int unsigned Depth = ucd_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  ucd_pkg::ucd_frame_t push_data,
	output logic                push_ready,
	output logic                pop_valid,
	output ucd_pkg::ucd_frame_t pop_data,
	input  logic                pop_ready
);
	import ucd_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	ucd_frame_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// File: rtl/core/ucd_back.sv
// id filter and output register of the result channel
module ucd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ucd_pkg::ucd_cfg_t   cfg,
	input  logic                pop_valid,
	input  ucd_pkg::ucd_frame_t pop_data,
	output logic                pop_ready,
	ucd_res_if.source           res
);
	import ucd_pkg::*;

	ucd_frame_t out_q;
	logic       out_valid_q;
	logic       pass;
	logic       do_pop;

	assign pass = ((pop_data.can_id >= cfg.msg_id_first) &&
		(pop_data.can_id <= cfg.msg_id_last)) ||
		(pop_data.can_id == cfg.status_id) ||
		(pop_data.can_id == cfg.heartbeat_id);

	assign pop_ready = !out_valid_q || res.ready;
	assign do_pop    = pop_valid && pop_ready;

	assign res.valid     = out_valid_q;
	assign res.can_id    = out_q.can_id;
	assign res.data_low  = out_q.data_low;
	assign res.data_high = out_q.data_high;

	always_ff @(posedge clk) begin
		if (do_pop) begin
			out_q <= pop_data;
		end
	end

	// a filtered-out frame is popped and dropped; it loads the output register but leaves res valid low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_pop) begin
			out_valid_q <= pass;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: bench/usb_can_frame_deframer_chk.sv
// checker: predicts filtered can frames from observed byte and register transfers
`timescale 1ns / 1ps
module usb_can_frame_deframer_chk (
	input  logic                      clk,
	input  logic                      arst_n,
	ucd_rx_if                         rx,
	ucd_res_if                        res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [ucd_pkg::AddrW-1:0] paddr,
	input  logic [ucd_pkg::DataW-1:0] pwdata,
	output int                        fail_count,
	output int                        frames_waiting,
	output int                        frames_checked
);
	import ucd_pkg::*;

	ucd_cfg_t         filt;
	logic [ByteW-1:0] held [HeldLen];
	int unsigned      held_cnt;
	ucd_frame_t       frames_due[$];

	function automatic bit id_passes(input logic [IdW-1:0] id);
		return (id >= filt.msg_id_first && id <= filt.msg_id_last) ||
			id == filt.status_id || id == filt.heartbeat_id;
	endfunction

	function automatic void check_field(input string name, input logic [WordW-1:0] want,
		input logic [WordW-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: error: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	// slide the byte window and queue a frame when a checked frame passes the filter
	task automatic take_byte(input logic [ByteW-1:0] b);
		logic [ByteW-1:0] f [HeldLen+1];
		logic [15:0]      s;
		logic [IdW-1:0]   id;
		ucd_frame_t       fr;
		if (held_cnt < HeldLen) begin
			held[held_cnt] = b;
			held_cnt++;
			return;
		end
		for (int i = 0; i < HeldLen; i++) f[i] = held[i];
		f[HeldLen] = b;
		s = '0;
		for (int i = 0; i < HeldLen; i++) s += 16'(f[i]);
		// two folds with end-around carry
		s = {8'h00, s[7:0]} + {8'h00, s[15:8]};
		s = {8'h00, s[7:0]} + {8'h00, s[15:8]};
		if (f[0] != StartMark || f[HeldLen] != ByteW'(16'h0 - s)) begin
			for (int i = 0; i < HeldLen - 1; i++) held[i] = held[i+1];
			held[HeldLen-1] = b;
			return;
		end
		held_cnt = 0;
		if (f[1] != TypeMark || f[2] != ChanMark) return;
		id = {f[4], f[5][7:5]};
		if (!id_passes(id)) return;
		fr.can_id    = id;
		fr.data_low  = {f[12], f[11], f[10], f[9]};
		fr.data_high = {f[16], f[15], f[14], f[13]};
		frames_due.push_back(fr);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ucd_frame_t want;
		if (!arst_n) begin
			filt.msg_id_first = MsgIdFirstRst;
			filt.msg_id_last  = MsgIdLastRst;
			filt.status_id    = StatusIdRst;
			filt.heartbeat_id = HeartbeatIdRst;
			for (int i = 0; i < HeldLen; i++) held[i] = '0;
			held_cnt = 0;
			frames_due.delete();
			fail_count = 0;
			frames_checked = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (frames_due.size() == 0) begin
					fail_count++;
					$display("%0t: error: unexpected frame id %h low %h high %h",
						$time, res.can_id, res.data_low, res.data_high);
				end else begin
					want = frames_due.pop_front();
					frames_checked++;
					check_field("can_id", WordW'(want.can_id), WordW'(res.can_id));
					check_field("data_low", want.data_low, res.data_low);
					check_field("data_high", want.data_high, res.data_high);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (ucd_reg_t'(paddr[AddrW-1:2]))
					REG_MSG_ID_FIRST: filt.msg_id_first = pwdata[IdW-1:0];
					REG_MSG_ID_LAST:  filt.msg_id_last  = pwdata[IdW-1:0];
					REG_STATUS_ID:    filt.status_id    = pwdata[IdW-1:0];
					REG_HEARTBEAT_ID: filt.heartbeat_id = pwdata[IdW-1:0];
					default: ;
				endcase
			end
			if (rx.valid && rx.ready) take_byte(rx.rx_byte);
		end
		frames_waiting = frames_due.size();
	end

endmodule

// File: bench/usb_can_frame_deframer_tb.sv
// testbench top: clock, reset, byte and register stimulus, verdict
`timescale 1ns / 1ps
module usb_can_frame_deframer_tb;
	import ucd_pkg::*;

	typedef logic [HeldLen:0][ByteW-1:0] frame_bytes_t;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic             pready;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	int               fail_count;
	int               frames_waiting;
	int               frames_checked;
	int               bytes_sent;
	int               settings_used;
	bit               idle_on;
	bit               hold_req;
	ucd_cfg_t         cfg_now;

	ucd_rx_if  rx_ch ();
	ucd_res_if res_ch ();

	usb_can_frame_deframer dut (
		.clk, .arst_n, .rx(rx_ch), .res(res_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	usb_can_frame_deframer_chk u_chk (
		.clk, .arst_n, .rx(rx_ch), .res(res_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .frames_waiting, .frames_checked
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("usb_can_frame_deframer: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!idle_on || r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [IdW-1:0] pick_id();
		case ($urandom_range(9))
			0, 1, 2, 3: return (cfg_now.msg_id_first <= cfg_now.msg_id_last) ?
				IdW'($urandom_range(cfg_now.msg_id_last, cfg_now.msg_id_first)) :
				IdW'($urandom);
			4: return cfg_now.status_id;
			5: return cfg_now.heartbeat_id;
			6: return cfg_now.msg_id_first - 1'b1;
			7: return cfg_now.msg_id_last + 1'b1;
			default: return IdW'($urandom);
		endcase
	endfunction

	// fill: 0 random bytes, 1 all zero, 2 all ones (largest sum)
	function automatic frame_bytes_t make_frame(input logic [IdW-1:0] id, input bit type_ok,
		input bit chan_ok, input bit sum_ok, input int fill);
		frame_bytes_t f;
		logic [15:0]  s;
		for (int i = 0; i <= HeldLen; i++)
			f[i] = (fill == 1) ? '0 : (fill == 2) ? '1 : ByteW'($urandom);
		f[0] = StartMark;
		if (type_ok) f[1] = TypeMark;
		else if (f[1] == TypeMark) f[1] = ~TypeMark;
		if (chan_ok) f[2] = ChanMark;
		else if (f[2] == ChanMark) f[2] = ~ChanMark;
		f[4] = id[IdW-1:3];
		f[5][7:5] = id[2:0];
		s = '0;
		for (int i = 0; i < HeldLen; i++) s += 16'(f[i]);
		s = {8'h00, s[7:0]} + {8'h00, s[15:8]};
		s = {8'h00, s[7:0]} + {8'h00, s[15:8]};
		f[HeldLen] = ByteW'(16'h0 - s) ^ (sum_ok ? 8'h00 : ByteW'($urandom_range(255, 1)));
		return f;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic push_byte(input logic [ByteW-1:0] b);
		int gap;
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_frame(input frame_bytes_t f);
		for (int i = 0; i <= HeldLen; i++) push_byte(f[i]);
	endtask

	task automatic write_reg(input ucd_reg_t r, input logic [IdW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		// upper bits are junk, the block keeps only the id bits
		pwdata  <= {(DataW-IdW)'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stop sending and let every frame in flight come out
	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (frames_waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_filter(input ucd_cfg_t c);
		settle();
		write_reg(REG_MSG_ID_FIRST, c.msg_id_first);
		write_reg(REG_MSG_ID_LAST, c.msg_id_last);
		write_reg(REG_STATUS_ID, c.status_id);
		write_reg(REG_HEARTBEAT_ID, c.heartbeat_id);
		cfg_now = c;
		settings_used++;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(99) < 30) begin
				res_ch.ready <= 1'b0;
				stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
				repeat (stall - 1) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		ucd_cfg_t     c;
		frame_bytes_t f;
		int           n;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		idle_on       = 1'b0;
		hold_req      = 1'b0;
		bytes_sent    = 0;
		settings_used = 1;
		cfg_now = '{MsgIdFirstRst, MsgIdLastRst, StatusIdRst, HeartbeatIdRst};
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default filter: range edges, just outside, extra ids, bad marks, bad checksum
		send_frame(make_frame(MsgIdFirstRst, 1, 1, 1, 0));
		send_frame(make_frame(MsgIdLastRst, 1, 1, 1, 0));
		send_frame(make_frame(MsgIdFirstRst - 1'b1, 1, 1, 1, 0));
		send_frame(make_frame(MsgIdLastRst + 1'b1, 1, 1, 1, 0));
		send_frame(make_frame(StatusIdRst, 1, 1, 1, 0));
		send_frame(make_frame(HeartbeatIdRst, 1, 1, 1, 0));
		send_frame(make_frame(MsgIdFirstRst, 0, 1, 1, 0));
		send_frame(make_frame(MsgIdFirstRst, 1, 0, 1, 0));
		send_frame(make_frame(MsgIdFirstRst, 1, 1, 0, 0));
		send_frame(make_frame(MsgIdLastRst, 1, 1, 1, 0));

		idle_on = 1'b1;
		c = '{11'd0, 11'd2047, 11'd0, 11'd2047};
		set_filter(c);
		send_frame(make_frame(11'd0, 1, 1, 1, 1));
		send_frame(make_frame(11'd2047, 1, 1, 1, 2));
		send_frame(make_frame(IdW'($urandom), 1, 1, 1, 0));

		// empty range, only the two extra ids get through
		c = '{11'd2047, 11'd0, 11'd5, 11'd2000};
		set_filter(c);
		send_frame(make_frame(11'd5, 1, 1, 1, 0));
		send_frame(make_frame(11'd2000, 1, 1, 1, 0));
		send_frame(make_frame(11'd1024, 1, 1, 1, 0));
		send_frame(make_frame(11'd0, 1, 1, 1, 0));
		send_frame(make_frame(11'd2047, 1, 1, 1, 0));

		// long output stall with back-to-back frames fills the block
		c = '{11'd0, 11'd2047, 11'd1, 11'd2};
		set_filter(c);
		idle_on  = 1'b0;
		hold_req = 1'b1;
		repeat (8) send_frame(make_frame(IdW'($urandom), 1, 1, 1, 0));
		idle_on = 1'b1;

		while (bytes_sent < 500) begin
			c.msg_id_first = IdW'($urandom);
			// wrap of the sum gives an empty range now and then
			c.msg_id_last  = c.msg_id_first + IdW'($urandom_range(40));
			c.status_id    = IdW'($urandom);
			c.heartbeat_id = IdW'($urandom);
			idle_on = ($urandom_range(3) != 0);
			set_filter(c);
			repeat ($urandom_range(15, 6)) begin
				n = $urandom_range(99);
				f = make_frame(pick_id(), $urandom_range(9) != 0, $urandom_range(9) != 0,
					$urandom_range(9) != 0,
					($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0);
				if (n < 70) begin
					send_frame(f);
				end else if (n < 85) begin
					repeat ($urandom_range(20, 1))
						push_byte(($urandom_range(3) == 0) ? StartMark : ByteW'($urandom));
				end else begin
					// truncated frame, the rest of the stream has to resync
					n = $urandom_range(HeldLen, 1);
					for (int i = 0; i < n; i++) push_byte(f[i]);
				end
			end
		end

		settle();
		repeat (16) @(negedge clk);
		$display("covered %0d received bytes and %0d checked frames over %0d filter settings,",
			bytes_sent, frames_checked, settings_used);
		$display("including empty and full id ranges and a long output stall");
		if (fail_count == 0 && frames_waiting == 0)
			$display("usb_can_frame_deframer: match");
		else
			$display("usb_can_frame_deframer: mismatch");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ucd_pkg.sv
rtl/core/ucd_channels.sv
rtl/core/ucd_cfg.sv
rtl/core/ucd_front.sv
rtl/core/ucd_queue.sv
rtl/core/ucd_back.sv
rtl/core/usb_can_frame_deframer.sv
bench/usb_can_frame_deframer_chk.sv
bench/usb_can_frame_deframer_tb.sv
